// ===== rtl/hstc_pkg.sv =====
// Package with the constants, codes and helper functions of the thermostat controller.
package hstc_pkg;

  localparam int TEMP_BITS = 16;
  // Working width for the band arithmetic: wide enough for setpoint plus or
  // minus four half-bands and for both saturation limits.
  localparam int CALC_W = (TEMP_BITS > 16) ? TEMP_BITS + 1 : 18;

  localparam int SAMPLE_W = 15;
  localparam int TARGET_W = 15;
  localparam int BAND_W = 10;
  localparam int MODE_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  typedef logic signed [CALC_W-1:0] calc_t;

  localparam calc_t TEMP_HI = {{(CALC_W-TEMP_BITS+1){1'b0}}, {(TEMP_BITS-1){1'b1}}};
  localparam calc_t TEMP_LO = ~TEMP_HI;
  localparam calc_t SP_MIN = calc_t'(340);
  localparam calc_t SP_MAX = calc_t'(5000);

  typedef enum logic [1:0] {
    CMD_OFF      = 2'd0,
    CMD_COOL     = 2'd1,
    CMD_HEAT     = 2'd2,
    CMD_HEAT_LOW = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STG_OFF  = 2'd0,
    STG_LOW  = 2'd1,
    STG_HIGH = 2'd2
  } stage_t;

  localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COOL      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HEAT      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEAT_COOL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TWO_STAGE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 15'd680;
  localparam logic [BAND_W-1:0]   BAND_RESET   = 10'd10;

  // Clip a working value to the signed range of TEMP_BITS bits.
  function automatic calc_t sat_temp(calc_t x);
    calc_t r;
    if (x > TEMP_HI) begin
      r = TEMP_HI;
    end else if (x < TEMP_LO) begin
      r = TEMP_LO;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

// ===== rtl/hysteresis_thermostat_controller.sv =====
// Hysteresis thermostat controller with two-stage heat, top level.
//
//   channel  direction  payload (lowest bit first)              handshake
//   s_*      in         sample_temp[14:0]                       tvalid/tready
//   m_*      out        drive_cmd[1:0], heat_stage[3:2]         tvalid/tready
//   cfg_*    in         0 target_temp, 1 band_width, 2 run_mode cfg_we only
//
// A sample is registered on acceptance and its result is registered once the output
// can take it; one sample is taken per cycle while the output is not stalled.
// The command and stage state update in the same cycle the result register loads.
// When the result is stalled the input register still takes one more sample.
// rst is synchronous and resets config, flags and state, not the data registers.
module hysteresis_thermostat_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,   // sample_temp[14:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,   // drive_cmd[1:0], heat_stage[3:2]
  input  logic                               cfg_we,
  input  logic [hstc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hstc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hstc_pkg::*;

  logic [TARGET_W-1:0] target_temp;
  logic [BAND_W-1:0]   band_width;
  logic [MODE_W-1:0]   run_mode;

  logic                in_valid;
  logic [SAMPLE_W-1:0] in_sample;

  cmd_t   cmd_reg, cmd_next;
  stage_t stage_reg, stage_next;

  logic   out_valid;
  cmd_t   out_cmd;
  stage_t out_stage;

  logic   advance;

  calc_t sp_raw, sp_clamp, sp, t, hi, lo, vlo, band_c, band4_c;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_stage, out_cmd};

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp <= TARGET_RESET;
      band_width  <= BAND_RESET;
      run_mode    <= MODE_OFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET: target_temp <= cfg_data[TARGET_W-1:0];
        REG_BAND:   band_width  <= cfg_data[BAND_W-1:0];
        REG_MODE:   run_mode    <= cfg_data[MODE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Band limits from the clamped setpoint.
  always_comb begin
    sp_raw  = {{(CALC_W-TARGET_W){target_temp[TARGET_W-1]}}, target_temp};
    band_c  = {{(CALC_W-BAND_W){1'b0}}, band_width};
    band4_c = {{(CALC_W-BAND_W-2){1'b0}}, band_width, 2'b00};
    if (sp_raw > SP_MAX) begin
      sp_clamp = SP_MAX;
    end else if (sp_raw < SP_MIN) begin
      sp_clamp = SP_MIN;
    end else begin
      sp_clamp = sp_raw;
    end
    t   = sat_temp({{(CALC_W-SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample});
    hi  = sat_temp(sp_clamp + band_c);
    lo  = sat_temp(sp_clamp - band_c);
    vlo = sat_temp(sp_clamp - band4_c);
    sp  = sat_temp(sp_clamp);
  end

  always_comb begin
    cmd_next   = cmd_reg;
    stage_next = stage_reg;
    case (run_mode)
      MODE_OFF: cmd_next = CMD_OFF;
      MODE_COOL: begin
        if (t >= hi) begin
          cmd_next = CMD_COOL;
        end else if (t <= lo) begin
          cmd_next = CMD_OFF;
        end
      end
      MODE_HEAT: begin
        if (t >= hi) begin
          cmd_next = CMD_OFF;
        end else if (t <= lo) begin
          cmd_next = CMD_HEAT;
        end
      end
      MODE_HEAT_COOL: begin
        if (t < lo) begin
          cmd_next = CMD_HEAT;
        end else if (t > hi) begin
          cmd_next = CMD_COOL;
        end else begin
          cmd_next = CMD_OFF;
        end
      end
      MODE_TWO_STAGE: begin
        unique case (stage_reg)
          STG_OFF: begin
            cmd_next = CMD_OFF;
            if (t <= lo) stage_next = STG_LOW;
          end
          STG_LOW: begin
            cmd_next = CMD_HEAT_LOW;
            if (t <= vlo) begin
              stage_next = STG_HIGH;
            end else if (t >= hi) begin
              stage_next = STG_OFF;
            end
          end
          STG_HIGH: begin
            cmd_next = CMD_HEAT;
            if (t > sp) stage_next = STG_LOW;
          end
          // The unused stage code keeps the command and recovers to high.
          default: stage_next = STG_HIGH;
        endcase
      end
      default: cmd_next = CMD_HEAT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      cmd_reg   <= CMD_OFF;
      stage_reg <= STG_OFF;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        cmd_reg   <= cmd_next;
        stage_reg <= stage_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SAMPLE_W-1:0];
    end
    if (advance) begin
      out_cmd   <= cmd_next;
      out_stage <= stage_next;
    end
  end

`ifndef SYNTHESIS
  a_stage_reachable: assert property (@(posedge clk) disable iff (rst)
    stage_reg != stage_t'(2'd3))
    else $error("unused heat stage code reached");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_tready |-> !s_tready)
    else $error("sample taken while both registers are full");

  a_off_mode: assert property (@(posedge clk) disable iff (rst)
    advance && run_mode == MODE_OFF |=> m_tdata[1:0] == CMD_OFF)
    else $error("off mode gave a drive command");

  a_heat_default: assert property (@(posedge clk) disable iff (rst)
    advance && run_mode > MODE_TWO_STAGE |=> m_tdata[1:0] == CMD_HEAT)
    else $error("high mode codes must drive heat");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_cmd == cmd_reg && out_stage == stage_reg)
    else $error("result register out of step with the state");
`endif

endmodule
